FILE: design/fct_pkg.sv
// Shared types, constants and helpers of the file chain table.
package fct_pkg;

  localparam int unsigned NUM_BLOCKS   = 256;
  localparam int unsigned ROOT_ENTRIES = 16;
  localparam int unsigned FAT_RESERVED = 11;

  localparam int unsigned BLK_W   = 8;
  localparam int unsigned CHAIN_W = 9;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DIR_W   = $clog2(ROOT_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS) + 1;

  localparam int unsigned FREE_START = FAT_RESERVED + 2;
  localparam logic [CHAIN_W-1:0] RSV_MARK = '1;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_REMOVE = 3'd1,
    OP_APPEND = 3'd2,
    OP_DELETE = 3'd3,
    OP_NEXT   = 3'd4,
    OP_FIRST  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NO_FILE   = 3'd2,
    ST_NOT_EMPTY = 3'd3,
    ST_DIR_FULL  = 3'd4,
    ST_DISK_FULL = 3'd5,
    ST_NOT_IN    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOOK, S_AP1, S_AP2, S_AP3, S_TW,
    S_WALK, S_NX, S_DL1, S_DL2, S_DL3, S_DONE
  } fsm_e;

  typedef struct packed {
    logic             create;
    logic             remove;
    logic             set_first;
    logic [DIR_W-1:0] idx;
    logic [BLK_W-1:0] first;
  } dir_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [DIR_W-1:0] hit_idx;
    logic [BLK_W-1:0] hit_first;
    logic             free_ok;
    logic [DIR_W-1:0] free_idx;
  } dir_look_t;

  // Reset image of the chain table: free list from FREE_START, reserved marks below.
  function automatic logic [CHAIN_W-1:0] chain_init(input logic [BLK_W-1:0] idx);
    logic [CHAIN_W-1:0] val;
    if (idx == '0) begin
      val = (FREE_START < NUM_BLOCKS) ? CHAIN_W'(FREE_START) : '0;
    end else if (32'(idx) < FREE_START) begin
      val = RSV_MARK;
    end else if (32'(idx) == NUM_BLOCKS - 1) begin
      val = '0;
    end else begin
      val = CHAIN_W'(idx) + CHAIN_W'(1);
    end
    return val;
  endfunction

endpackage

FILE: design/fct_if.sv
// Valid/ready channel interfaces for operations and results.
interface fct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] file_key;
  logic [7:0]  block_number;
  modport source (output valid, opcode, file_key, block_number, input ready);
  modport sink (input valid, opcode, file_key, block_number, output ready);
endinterface

interface fct_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] block_result;
  modport source (output valid, status, block_result, input ready);
  modport sink (input valid, status, block_result, output ready);
endinterface

FILE: design/fct_chain_ram.sv
// Chain table memory: one write port, one registered read port, write-through.
module fct_chain_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // A read of the entry written in the same cycle sees the new value.
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

FILE: design/fct_directory.sv
// Root directory: valid, name and first block per entry, with name lookup.
module fct_directory import fct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KEY_W-1:0] key_i,
  input  dir_cmd_t         cmd_i,
  output dir_look_t        look_o
);
  logic             valid_q [ROOT_ENTRIES];
  logic [KEY_W-1:0] name_q  [ROOT_ENTRIES];
  logic [BLK_W-1:0] first_q [ROOT_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        first_q[i] <= '0;
      end
    end else begin
      if (cmd_i.create) begin
        valid_q[cmd_i.idx] <= 1'b1;
        first_q[cmd_i.idx] <= '0;
      end
      if (cmd_i.remove) begin
        valid_q[cmd_i.idx] <= 1'b0;
        first_q[cmd_i.idx] <= '0;
      end
      if (cmd_i.set_first) begin
        first_q[cmd_i.idx] <= cmd_i.first;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      name_q[cmd_i.idx] <= key_i;
    end
  end

  // Scan from the top so the lowest matching index wins.
  always_comb begin
    look_o = '0;
    for (int i = ROOT_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (name_q[i] == key_i)) begin
        look_o.hit       = 1'b1;
        look_o.hit_idx   = DIR_W'(i);
        look_o.hit_first = first_q[i];
      end
      if (!valid_q[i]) begin
        look_o.free_ok  = 1'b1;
        look_o.free_idx = DIR_W'(i);
      end
    end
  end
endmodule

FILE: design/fat_file_chain_table.sv
// Top level of the file chain table: operation sequencer around the chain memory.
//
// One operation beat enters on in_i (opcode, file_key, block_number) and one
// result beat leaves on out_o (status, block_result). Both are valid/ready.
// The block works on one operation at a time; in_i.ready is high while the
// sequencer is idle, also while the previous result still waits on out_o.
// Create, remove, first and unknown opcodes and a failed name lookup need no
// chain walk; next and delete walk the file's chain up to the matching block
// (or to its end when the block is not in the file), and append walks the
// whole chain to link the new block at its tail unless the disk is full or
// the file is empty. The walk over the chain memory makes one read per cycle.
// After reset the block writes the initial chain table (free list and
// reserved marks) and takes no operation until that is done.
// If out_o.ready is low the result is held in the output register and the
// next operation may still be accepted; its result waits until that slot frees.
module fat_file_chain_table import fct_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  fct_in_if.sink   in_i,
  fct_out_if.source out_o
);
  fsm_e               state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [CHAIN_W-1:0] cur_q, cur_d;
  logic [BLK_W-1:0]   prev_q, prev_d;
  logic               use_rd_q, use_rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BLK_W-1:0]   alloc_q, alloc_d;
  logic [BLK_W-1:0]   init_q, init_d;
  status_e            st_q, st_d;
  logic [BLK_W-1:0]   res_q, res_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_st_q, out_st_d;
  logic [BLK_W-1:0]   out_res_q, out_res_d;

  logic               mem_we;
  logic [BLK_W-1:0]   mem_waddr, mem_raddr;
  logic [CHAIN_W-1:0] mem_wdata, mem_rdata;

  dir_cmd_t  dir_cmd;
  dir_look_t look;

  logic               accept, out_free;
  logic [CHAIN_W-1:0] wk_b;
  logic               wk_stop, wk_hit, link_end, tw_last;

  fct_chain_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(CHAIN_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fct_directory u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .cmd_i  (dir_cmd),
    .look_o (look)
  );

  assign in_i.ready         = (state_q == S_IDLE);
  assign accept             = in_i.valid && in_i.ready;
  assign out_free           = !out_valid_q || out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_st_q;
  assign out_o.block_result = out_res_q;

  // The walk looks at the first block once, then at each link as it returns.
  assign wk_b     = use_rd_q ? mem_rdata : cur_q;
  assign wk_stop  = cnt_q[CNT_W-1] || (wk_b == '0) || wk_b[CHAIN_W-1];
  assign wk_hit   = !wk_stop && (wk_b[BLK_W-1:0] == blk_q);
  assign link_end = (mem_rdata == '0) || mem_rdata[CHAIN_W-1];
  assign tw_last  = (cnt_q == CNT_W'(NUM_BLOCKS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: if (init_q == BLK_W'(NUM_BLOCKS - 1)) state_d = S_IDLE;
      S_IDLE: if (accept) state_d = S_LOOK;
      S_LOOK: begin
        case (op_e'(op_q))
          OP_APPEND: state_d = look.hit ? S_AP1 : S_DONE;
          OP_DELETE, OP_NEXT: begin
            state_d = (look.hit && (blk_q != '0)) ? S_WALK : S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_AP1: state_d = link_end ? S_DONE : S_AP2;
      S_AP2: state_d = S_AP3;
      S_AP3: state_d = (look.hit_first == '0) ? S_DONE : S_TW;
      S_TW: if (link_end || tw_last) state_d = S_DONE;
      S_WALK: begin
        if (wk_stop) begin
          state_d = S_DONE;
        end else if (wk_hit) begin
          state_d = (op_e'(op_q) == OP_NEXT) ? S_NX : S_DL1;
        end
      end
      S_NX:  state_d = S_DONE;
      S_DL1: state_d = S_DL2;
      S_DL2: state_d = S_DL3;
      S_DL3: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    blk_d       = blk_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    use_rd_d    = use_rd_q;
    cnt_d       = cnt_q;
    alloc_d     = alloc_q;
    init_d      = init_q;
    st_d        = st_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_st_d    = out_st_q;
    out_res_d   = out_res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    dir_cmd     = '0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = chain_init(init_q);
        init_d    = init_q + BLK_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_d  = in_i.opcode;
          key_d = in_i.file_key;
          blk_d = in_i.block_number;
        end
      end
      S_LOOK: begin
        st_d  = ST_OK;
        res_d = '0;
        case (op_e'(op_q))
          OP_CREATE: begin
            if (look.hit) begin
              st_d = ST_EXISTS;
            end else if (!look.free_ok) begin
              st_d = ST_DIR_FULL;
            end else begin
              dir_cmd.create = 1'b1;
              dir_cmd.idx    = look.free_idx;
            end
          end
          OP_REMOVE: begin
            if (!look.hit) begin
              st_d = ST_NO_FILE;
            end else if (look.hit_first != '0) begin
              st_d = ST_NOT_EMPTY;
            end else begin
              dir_cmd.remove = 1'b1;
              dir_cmd.idx    = look.hit_idx;
            end
          end
          OP_APPEND: begin
            if (!look.hit) st_d = ST_NO_FILE;
            mem_raddr = '0;
          end
          OP_DELETE, OP_NEXT: begin
            if (!look.hit) begin
              st_d = ST_NO_FILE;
            end else if (blk_q == '0) begin
              st_d = ST_NOT_IN;
            end
            cur_d    = {1'b0, look.hit_first};
            use_rd_d = 1'b0;
            cnt_d    = '0;
            prev_d   = '0;
          end
          OP_FIRST: begin
            if (!look.hit) begin
              st_d = ST_NO_FILE;
            end else begin
              res_d = look.hit_first;
            end
          end
          default: ;
        endcase
      end
      S_AP1: begin
        if (link_end) begin
          st_d = ST_DISK_FULL;
        end else begin
          alloc_d   = mem_rdata[BLK_W-1:0];
          mem_raddr = mem_rdata[BLK_W-1:0];
        end
      end
      S_AP2: begin
        // Pop the free list head.
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
      end
      S_AP3: begin
        mem_we    = 1'b1;
        mem_waddr = alloc_q;
        mem_wdata = '0;
        res_d     = alloc_q;
        if (look.hit_first == '0) begin
          dir_cmd.set_first = 1'b1;
          dir_cmd.idx       = look.hit_idx;
          dir_cmd.first     = alloc_q;
        end else begin
          mem_raddr = look.hit_first;
          cur_d     = {1'b0, look.hit_first};
          cnt_d     = '0;
        end
      end
      S_TW: begin
        if (link_end) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q[BLK_W-1:0];
          mem_wdata = {1'b0, alloc_q};
        end else if (tw_last) begin
          mem_we    = 1'b1;
          mem_waddr = mem_rdata[BLK_W-1:0];
          mem_wdata = {1'b0, alloc_q};
        end else begin
          cur_d     = mem_rdata;
          mem_raddr = mem_rdata[BLK_W-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      S_WALK: begin
        if (wk_stop) begin
          st_d = ST_NOT_IN;
        end else if (wk_hit) begin
          mem_raddr = blk_q;
        end else begin
          prev_d    = wk_b[BLK_W-1:0];
          mem_raddr = wk_b[BLK_W-1:0];
          use_rd_d  = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      S_NX: res_d = mem_rdata[BLK_W-1:0];
      S_DL1: begin
        // Unlink the block from its predecessor or from the directory entry.
        if (look.hit_first == blk_q) begin
          dir_cmd.set_first = 1'b1;
          dir_cmd.idx       = look.hit_idx;
          dir_cmd.first     = mem_rdata[BLK_W-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = mem_rdata;
        end
        mem_raddr = '0;
      end
      S_DL2: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q;
        mem_wdata = mem_rdata;
      end
      S_DL3: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b0, blk_q};
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_res_d   = (st_q == ST_OK) ? res_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
      use_rd_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      use_rd_q    <= use_rd_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    blk_q     <= blk_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    alloc_q   <= alloc_d;
    st_q      <= st_d;
    res_q     <= res_d;
    out_st_q  <= out_st_d;
    out_res_q <= out_res_d;
  end

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOOK)
    else $error("accepted beat did not start a lookup");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> !mem_we)
    else $error("chain memory written during membership walk");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result beat raised outside the completion state");

  a_init_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !in_i.ready)
    else $error("operation taken during chain table initialization");

endmodule
